// ----- rtl/jsod_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jsod_pkg;

   localparam int MAX_RESULTS = 5;
   localparam int FIFO_DEPTH  = 8;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
   // an item is taken only while a whole burst still fits
   localparam int ROOM_LIMIT  = FIFO_DEPTH - MAX_RESULTS;

   localparam logic [2:0] KIND_KEY_BYTE = 3'd0;
   localparam logic [2:0] KIND_VAL_BYTE = 3'd1;
   localparam logic [2:0] KIND_KEY_END  = 3'd2;
   localparam logic [2:0] KIND_VAL_END  = 3'd3;
   localparam logic [2:0] KIND_ACCEPT   = 3'd4;
   localparam logic [2:0] KIND_ERROR    = 3'd5;

   localparam logic [3:0] ERR_MALFORMED = 4'd0;
   localparam logic [3:0] ERR_TRAILING  = 4'd1;
   localparam logic [3:0] ERR_CONTROL   = 4'd2;
   localparam logic [3:0] ERR_UNTERM    = 4'd3;
   localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
   localparam logic [3:0] ERR_BAD_HEX   = 4'd5;
   localparam logic [3:0] ERR_TRUNC_UNI = 4'd6;
   localparam logic [3:0] ERR_UNP_HIGH  = 4'd7;
   localparam logic [3:0] ERR_BAD_PAIR  = 4'd8;
   localparam logic [3:0] ERR_UNP_LOW   = 4'd9;
   localparam logic [3:0] ERR_TRUNC_ESC = 4'd10;

   typedef enum logic [3:0] {
      PH_OPEN      = 4'd0,
      PH_FIRST     = 4'd1,
      PH_KEY_OPEN  = 4'd2,
      PH_COLON     = 4'd3,
      PH_VAL_OPEN  = 4'd4,
      PH_AFTER_VAL = 4'd5,
      PH_TAIL      = 4'd6,
      PH_STR       = 4'd7,
      PH_ESC       = 4'd8,
      PH_HEX       = 4'd9,
      PH_HI_BS     = 4'd10,
      PH_HI_U      = 4'd11,
      PH_LO_HEX    = 4'd12
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic        in_value;
      logic [15:0] hex_accum;
      logic [1:0]  hex_count;
      logic [9:0]  high_sur;
      logic        discarding;
   } dec_state_type;

   localparam dec_state_type STATE_RESET = '{
      phase:      PH_OPEN,
      in_value:   1'b0,
      hex_accum:  16'h0000,
      hex_count:  2'd0,
      high_sur:   10'd0,
      discarding: 1'b0
   };

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [3:0] err;
      logic       run_end;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- rtl/jsod_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jsod_decode (
   input  jsod_pkg::dec_state_type                              cur_state,
   input  logic [7:0]                                           text_byte,
   input  logic                                                 text_last,
   output jsod_pkg::dec_state_type                              nxt_state,
   output jsod_pkg::rsp_item_type [jsod_pkg::MAX_RESULTS-1:0]   res_items,
   output logic [2:0]                                           res_count
);
   import jsod_pkg::*;

   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] bytes;
   } utf8_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type u;
      u = '0;
      if (cp <= 21'h00007f) begin
         u.len      = 3'd1;
         u.bytes[0] = cp[7:0];
      end else if (cp <= 21'h0007ff) begin
         u.len      = 3'd2;
         u.bytes[0] = 8'hc0 | {3'b000, cp[10:6]};
         u.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      end else if (cp <= 21'h00ffff) begin
         u.len      = 3'd3;
         u.bytes[0] = 8'he0 | {4'b0000, cp[15:12]};
         u.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
         u.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         u.len      = 3'd4;
         u.bytes[0] = 8'hf0 | {5'b00000, cp[20:18]};
         u.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
         u.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
         u.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      end
      return u;
   endfunction

   // {valid, digit}
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   dec_state_type   nxt;
   utf8_type        enc;
   logic [2:0]      data_n;
   logic [3:0][7:0] data_b;
   logic            mark;
   logic            term;
   logic [2:0]      term_kind;
   logic [3:0]      term_err;
   logic [4:0]      hv;
   logic [15:0]     acc;
   logic [20:0]     cp;
   logic            is_space;
   logic            in_struct;
   logic            low;
   logic [2:0]      idx;

   always_comb begin
      nxt       = cur_state;
      enc       = '0;
      data_n    = 3'd0;
      data_b    = '0;
      mark      = 1'b0;
      term      = 1'b0;
      term_kind = KIND_ERROR;
      term_err  = ERR_MALFORMED;
      hv        = hex_nibble(text_byte);
      acc       = {cur_state.hex_accum[11:0], hv[3:0]};
      cp        = 21'h010000 + {1'b0, cur_state.high_sur, acc[9:0]};
      is_space  = text_byte == 8'h20 || text_byte == 8'h09 ||
                  text_byte == 8'h0a || text_byte == 8'h0d;
      in_struct = cur_state.phase <= PH_TAIL;
      low       = cur_state.phase == PH_LO_HEX;

      if (cur_state.discarding) begin
         if (cur_state.hex_count != 2'd0) begin
            nxt.hex_count = cur_state.hex_count - 2'd1;
         end
      end else if (in_struct && is_space) begin
         nxt = cur_state;
      end else begin
         case (cur_state.phase)
            PH_OPEN: begin
               if (text_byte == 8'h7b) begin
                  nxt.phase = PH_FIRST;
               end else begin
                  nxt.discarding = 1'b1;
                  nxt.hex_accum  = {12'h000, ERR_MALFORMED};
                  nxt.hex_count  = 2'd0;
               end
            end
            PH_FIRST, PH_KEY_OPEN, PH_VAL_OPEN: begin
               if (cur_state.phase == PH_FIRST && text_byte == 8'h7d) begin
                  nxt.phase = PH_TAIL;
               end else if (text_byte == 8'h22) begin
                  nxt.in_value = cur_state.phase == PH_VAL_OPEN;
                  nxt.phase    = PH_STR;
               end else begin
                  nxt.discarding = 1'b1;
                  nxt.hex_accum  = {12'h000, ERR_MALFORMED};
                  nxt.hex_count  = 2'd0;
               end
            end
            PH_COLON: begin
               if (text_byte == 8'h3a) begin
                  nxt.phase = PH_VAL_OPEN;
               end else begin
                  nxt.discarding = 1'b1;
                  nxt.hex_accum  = {12'h000, ERR_MALFORMED};
                  nxt.hex_count  = 2'd0;
               end
            end
            PH_AFTER_VAL: begin
               if (text_byte == 8'h7d) begin
                  nxt.phase = PH_TAIL;
               end else if (text_byte == 8'h2c) begin
                  nxt.phase = PH_KEY_OPEN;
               end else begin
                  nxt.discarding = 1'b1;
                  nxt.hex_accum  = {12'h000, ERR_MALFORMED};
                  nxt.hex_count  = 2'd0;
               end
            end
            PH_TAIL: begin
               nxt.discarding = 1'b1;
               nxt.hex_accum  = {12'h000, ERR_TRAILING};
               nxt.hex_count  = 2'd0;
            end
            PH_STR: begin
               if (text_byte == 8'h22) begin
                  mark      = 1'b1;
                  nxt.phase = cur_state.in_value ? PH_AFTER_VAL : PH_COLON;
               end else if (text_byte < 8'h20) begin
                  nxt.discarding = 1'b1;
                  nxt.hex_accum  = {12'h000, ERR_CONTROL};
                  nxt.hex_count  = 2'd0;
               end else if (text_byte == 8'h5c) begin
                  nxt.phase = PH_ESC;
               end else begin
                  data_n    = 3'd1;
                  data_b[0] = text_byte;
               end
            end
            PH_ESC: begin
               nxt.phase = PH_STR;
               data_n    = 3'd1;
               case (text_byte)
                  8'h22:   data_b[0] = 8'h22;
                  8'h5c:   data_b[0] = 8'h5c;
                  8'h2f:   data_b[0] = 8'h2f;
                  8'h62:   data_b[0] = 8'h08;
                  8'h66:   data_b[0] = 8'h0c;
                  8'h6e:   data_b[0] = 8'h0a;
                  8'h72:   data_b[0] = 8'h0d;
                  8'h74:   data_b[0] = 8'h09;
                  8'h75: begin
                     data_n        = 3'd0;
                     nxt.phase     = PH_HEX;
                     nxt.hex_accum = 16'h0000;
                     nxt.hex_count = 2'd0;
                  end
                  default: begin
                     data_n         = 3'd0;
                     nxt.discarding = 1'b1;
                     nxt.hex_accum  = {12'h000, ERR_BAD_ESC};
                     nxt.hex_count  = 2'd0;
                  end
               endcase
            end
            PH_HEX, PH_LO_HEX: begin
               if (!hv[4]) begin
                  // bytes left in this group of four decide bad hex or truncation
                  nxt.discarding = 1'b1;
                  nxt.hex_accum  = {12'h000, ERR_BAD_HEX};
                  nxt.hex_count  = 2'd3 - cur_state.hex_count;
               end else if (cur_state.hex_count != 2'd3) begin
                  nxt.hex_accum = acc;
                  nxt.hex_count = cur_state.hex_count + 2'd1;
               end else begin
                  nxt.hex_accum = 16'h0000;
                  nxt.hex_count = 2'd0;
                  if (low) begin
                     if (acc[15:10] != 6'b110111) begin
                        nxt.discarding = 1'b1;
                        nxt.hex_accum  = {12'h000, ERR_BAD_PAIR};
                     end else begin
                        enc       = utf8_encode(cp);
                        data_n    = enc.len;
                        data_b    = enc.bytes;
                        nxt.phase = PH_STR;
                     end
                  end else if (acc[15:10] == 6'b110110) begin
                     nxt.high_sur = acc[9:0];
                     nxt.phase    = PH_HI_BS;
                  end else if (acc[15:10] == 6'b110111) begin
                     nxt.discarding = 1'b1;
                     nxt.hex_accum  = {12'h000, ERR_UNP_LOW};
                  end else begin
                     enc       = utf8_encode({5'b00000, acc});
                     data_n    = enc.len;
                     data_b    = enc.bytes;
                     nxt.phase = PH_STR;
                  end
               end
            end
            PH_HI_BS: begin
               if (text_byte == 8'h5c) begin
                  nxt.phase = PH_HI_U;
               end else begin
                  nxt.discarding = 1'b1;
                  nxt.hex_accum  = {12'h000, ERR_UNP_HIGH};
                  nxt.hex_count  = 2'd0;
               end
            end
            PH_HI_U: begin
               if (text_byte == 8'h75) begin
                  nxt.phase     = PH_LO_HEX;
                  nxt.hex_accum = 16'h0000;
                  nxt.hex_count = 2'd0;
               end else begin
                  nxt.discarding = 1'b1;
                  nxt.hex_accum  = {12'h000, ERR_UNP_HIGH};
                  nxt.hex_count  = 2'd0;
               end
            end
            default: begin
               nxt.discarding = 1'b1;
               nxt.hex_accum  = {12'h000, ERR_MALFORMED};
               nxt.hex_count  = 2'd0;
            end
         endcase
      end

      if (text_last) begin
         term = 1'b1;
         if (nxt.discarding) begin
            term_err = nxt.hex_accum[3:0];
            if (term_err == ERR_BAD_HEX && nxt.hex_count != 2'd0) begin
               term_err = ERR_TRUNC_UNI;
            end
         end else begin
            case (nxt.phase)
               PH_TAIL:             term_kind = KIND_ACCEPT;
               PH_STR:              term_err  = ERR_UNTERM;
               PH_ESC:              term_err  = ERR_TRUNC_ESC;
               PH_HEX, PH_LO_HEX:   term_err  = ERR_TRUNC_UNI;
               PH_HI_BS, PH_HI_U:   term_err  = ERR_UNP_HIGH;
               default:             term_err  = ERR_MALFORMED;
            endcase
         end
         if (term_kind == KIND_ACCEPT) begin
            term_err = ERR_MALFORMED;
         end
         nxt = STATE_RESET;
      end

      // data bytes first, then the end mark, then the terminal report
      res_items = '0;
      for (int i = 0; i < 4; i++) begin
         if (i < data_n) begin
            res_items[i].kind = {2'b00, cur_state.in_value};
            res_items[i].data = data_b[i];
         end
      end
      idx = data_n;
      if (mark) begin
         res_items[idx].kind = cur_state.in_value ? KIND_VAL_END : KIND_KEY_END;
         idx = idx + 3'd1;
      end
      if (term) begin
         res_items[idx].kind = term_kind;
         res_items[idx].err  = term_err;
         idx = idx + 3'd1;
      end
      if (idx != 3'd0) begin
         res_items[idx - 3'd1].run_end = 1'b1;
      end
      res_count = idx;
      nxt_state = nxt;
   end

endmodule

`default_nettype wire

// ----- rtl/json_string_object_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  tdata                         tuser          tlast
// req      in         [7:0] text byte               -              last byte of text
// rsp      out        [7:0] byte, [11:8] error code  [2:0] kind    last result of a byte
//
// one text byte per cycle while room allows: a byte is held in the input register,
// decoded in a single pass and its 0 to 5 results go into an 8-entry result queue.
// the input register takes a byte while empty or the queue has room for a full burst
// (at most 3 entries held); results leave at one per cycle, so bursts slow it down.
// reset (synchronous) empties the queue and sets the parser to wait for an opening brace.
// a stalled rsp side fills the queue and then holds req_tready low.

module json_string_object_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] res_byte, [11:8] res_error, [15:12] zero
   output logic [2:0]  rsp_tuser,   // [2:0] res_kind
   output logic        rsp_tlast
);
   import jsod_pkg::*;

   logic                                in_valid_ff, in_valid_in;
   logic [7:0]                          in_byte_ff;
   logic                                in_last_ff;
   dec_state_type                       state_ff, state_in;
   rsp_item_type                        fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]                    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   dec_state_type                       dec_next;
   rsp_item_type [MAX_RESULTS-1:0]      dec_items;
   logic [2:0]                          dec_count;
   logic                                room;
   logic                                advance;
   logic                                pop;
   logic [CNT_W-1:0]                    push_n;
   rsp_item_type                        head;

   jsod_decode u_decode (
      .cur_state (state_ff),
      .text_byte (in_byte_ff),
      .text_last (in_last_ff),
      .nxt_state (dec_next),
      .res_items (dec_items),
      .res_count (dec_count)
   );

   assign room       = count_ff <= CNT_W'(ROOM_LIMIT);
   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign pop        = rsp_tvalid && rsp_tready;
   assign push_n     = advance ? CNT_W'(dec_count) : '0;

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {4'b0000, head.err, head.data};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.run_end;

   always_comb begin
      in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      state_in    = advance ? dec_next : state_ff;
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
      count_in    = count_ff + push_n - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (advance && i < dec_count) begin
            fifo_ff[wr_ptr_ff + PTR_W'(i)] <= dec_items[i];
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/jsod_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jsod_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import jsod_pkg::*;

   // queue is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result queue not empty after reset");

   // a waiting result item stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // only data bytes carry a byte value
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_KEY_BYTE && rsp_tuser != KIND_VAL_BYTE
      |-> rsp_tdata[7:0] == 8'h00)
      else $error("non-data item carries a byte");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_ERROR |-> rsp_tdata[15:8] == 8'h00)
      else $error("error code on a non-error item");

   // the final report always closes the run of its byte
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ACCEPT || rsp_tuser == KIND_ERROR) |-> rsp_tlast)
      else $error("final report without tlast");

endmodule

bind json_string_object_decoder_unit jsod_checker u_jsod_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import jsod_pkg::*;

   typedef logic [7:0] text_type[$];

   localparam logic [3:0] NO_ERROR    = 4'd0;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5c;
   localparam logic [7:0] CH_LBRACE   = 8'h7b;
   localparam logic [7:0] CH_RBRACE   = 8'h7d;
   localparam logic [7:0] CH_COLON    = 8'h3a;
   localparam logic [7:0] CH_COMMA    = 8'h2c;
   localparam logic [7:0] CH_U        = 8'h75;
   localparam int         CYCLE_LIMIT = 300000;

   localparam logic [7:0]  BLANKS [4]   = '{8'h20, 8'h09, 8'h0a, 8'h0d};
   localparam logic [15:0] BOUND_CP [8] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
                                           16'h0800, 16'hd7ff, 16'he000, 16'hffff};

   class decode_board;
      phase_type    phase;
      logic         in_value;
      logic [15:0]  hex_accum;
      logic [1:0]   hex_count;
      logic [9:0]   high_sur;
      logic         discarding;
      rsp_item_type pending[$];
      rsp_item_type burst[$];
      int           mismatches = 0;
      int           checked = 0;
      int           bytes_seen = 0;
      int           accepts = 0;
      logic [10:0]  codes_seen = '0;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         phase      = PH_OPEN;
         in_value   = 1'b0;
         hex_accum  = '0;
         hex_count  = '0;
         high_sur   = '0;
         discarding = 1'b0;
      endfunction

      function void emit(logic [2:0] kind, logic [7:0] data, logic [3:0] err);
         rsp_item_type r;
         r.kind    = kind;
         r.data    = data;
         r.err     = err;
         r.run_end = 1'b0;
         burst.insert(burst.size(), r);
      endfunction

      function void fail_with(logic [3:0] code, int remaining);
         discarding = 1'b1;
         hex_accum  = {12'h000, code};
         hex_count  = remaining[1:0];
      endfunction

      function int nibble_of(logic [7:0] b);
         if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
         if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
         if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
         return -1;
      endfunction

      function void emit_utf8(logic [31:0] cp);
         logic [2:0] k;
         k = in_value ? KIND_VAL_BYTE : KIND_KEY_BYTE;
         if (cp <= 32'h7f) begin
            emit(k, cp[7:0], NO_ERROR);
         end else if (cp <= 32'h7ff) begin
            emit(k, 8'hc0 | cp[10:6], NO_ERROR);
            emit(k, 8'h80 | cp[5:0], NO_ERROR);
         end else if (cp <= 32'hffff) begin
            emit(k, 8'he0 | cp[15:12], NO_ERROR);
            emit(k, 8'h80 | cp[11:6], NO_ERROR);
            emit(k, 8'h80 | cp[5:0], NO_ERROR);
         end else begin
            emit(k, 8'hf0 | cp[20:18], NO_ERROR);
            emit(k, 8'h80 | cp[17:12], NO_ERROR);
            emit(k, 8'h80 | cp[11:6], NO_ERROR);
            emit(k, 8'h80 | cp[5:0], NO_ERROR);
         end
      endfunction

      function void take_hex(logic [7:0] b, logic low);
         int          d;
         logic [15:0] v;
         d = nibble_of(b);
         if (d < 0) begin
            fail_with(ERR_BAD_HEX, 3 - hex_count);
            return;
         end
         hex_accum = {hex_accum[11:0], d[3:0]};
         if (hex_count < 2'd3) begin
            hex_count++;
            return;
         end
         v         = hex_accum;
         hex_count = '0;
         hex_accum = '0;
         if (low) begin
            if (v < 16'hdc00 || v > 16'hdfff) begin
               fail_with(ERR_BAD_PAIR, 0);
               return;
            end
            emit_utf8(32'h10000 + {12'h000, high_sur, v[9:0]});
            phase = PH_STR;
         end else if (v >= 16'hd800 && v <= 16'hdbff) begin
            high_sur = v[9:0];
            phase    = PH_HI_BS;
         end else if (v >= 16'hdc00 && v <= 16'hdfff) begin
            fail_with(ERR_UNP_LOW, 0);
         end else begin
            emit_utf8({16'h0000, v});
            phase = PH_STR;
         end
      endfunction

      function void open_str(logic [7:0] b, logic val);
         if (b == CH_QUOTE) begin
            in_value = val;
            phase    = PH_STR;
         end else begin
            fail_with(ERR_MALFORMED, 0);
         end
      endfunction

      function void take_byte(logic [7:0] b);
         logic [7:0] c;
         logic       ok;
         if (phase <= PH_TAIL && (b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d))
            return;
         case (phase)
            PH_OPEN: begin
               if (b == CH_LBRACE) phase = PH_FIRST;
               else fail_with(ERR_MALFORMED, 0);
            end
            PH_FIRST: begin
               if (b == CH_RBRACE) phase = PH_TAIL;
               else open_str(b, 1'b0);
            end
            PH_KEY_OPEN: open_str(b, 1'b0);
            PH_COLON: begin
               if (b == CH_COLON) phase = PH_VAL_OPEN;
               else fail_with(ERR_MALFORMED, 0);
            end
            PH_VAL_OPEN: open_str(b, 1'b1);
            PH_AFTER_VAL: begin
               if (b == CH_RBRACE) phase = PH_TAIL;
               else if (b == CH_COMMA) phase = PH_KEY_OPEN;
               else fail_with(ERR_MALFORMED, 0);
            end
            PH_TAIL: fail_with(ERR_TRAILING, 0);
            PH_STR: begin
               if (b == CH_QUOTE) begin
                  if (in_value) begin
                     emit(KIND_VAL_END, 8'h00, NO_ERROR);
                     phase = PH_AFTER_VAL;
                  end else begin
                     emit(KIND_KEY_END, 8'h00, NO_ERROR);
                     phase = PH_COLON;
                  end
               end else if (b < 8'h20) begin
                  fail_with(ERR_CONTROL, 0);
               end else if (b == CH_BSLASH) begin
                  phase = PH_ESC;
               end else begin
                  emit(in_value ? KIND_VAL_BYTE : KIND_KEY_BYTE, b, NO_ERROR);
               end
            end
            PH_ESC: begin
               phase = PH_STR;
               ok    = 1'b1;
               c     = 8'h00;
               case (b)
                  CH_QUOTE:  c = CH_QUOTE;
                  CH_BSLASH: c = CH_BSLASH;
                  8'h2f:     c = 8'h2f;   // solidus
                  8'h62:     c = 8'h08;   // b
                  8'h66:     c = 8'h0c;   // f
                  8'h6e:     c = 8'h0a;   // n
                  8'h72:     c = 8'h0d;   // r
                  8'h74:     c = 8'h09;   // t
                  CH_U: begin
                     phase     = PH_HEX;
                     hex_accum = '0;
                     hex_count = '0;
                     ok        = 1'b0;
                  end
                  default: begin
                     fail_with(ERR_BAD_ESC, 0);
                     ok = 1'b0;
                  end
               endcase
               if (ok) emit(in_value ? KIND_VAL_BYTE : KIND_KEY_BYTE, c, NO_ERROR);
            end
            PH_HEX: take_hex(b, 1'b0);
            PH_HI_BS: begin
               if (b == CH_BSLASH) phase = PH_HI_U;
               else fail_with(ERR_UNP_HIGH, 0);
            end
            PH_HI_U: begin
               if (b == CH_U) begin
                  phase     = PH_LO_HEX;
                  hex_accum = '0;
                  hex_count = '0;
               end else begin
                  fail_with(ERR_UNP_HIGH, 0);
               end
            end
            PH_LO_HEX: take_hex(b, 1'b1);
            default: fail_with(ERR_MALFORMED, 0);
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [3:0]   code;
         rsp_item_type r;
         burst.delete();
         bytes_seen++;
         if (discarding) begin
            if (hex_count > 0) hex_count--;
         end else begin
            take_byte(b);
         end
         if (last) begin
            if (discarding) begin
               code = hex_accum[3:0];
               // text ended inside the group that held the bad digit
               if (code == ERR_BAD_HEX && hex_count > 0) code = ERR_TRUNC_UNI;
               emit(KIND_ERROR, 8'h00, code);
            end else begin
               case (phase)
                  PH_TAIL:             emit(KIND_ACCEPT, 8'h00, NO_ERROR);
                  PH_STR:              emit(KIND_ERROR, 8'h00, ERR_UNTERM);
                  PH_ESC:              emit(KIND_ERROR, 8'h00, ERR_TRUNC_ESC);
                  PH_HEX, PH_LO_HEX:   emit(KIND_ERROR, 8'h00, ERR_TRUNC_UNI);
                  PH_HI_BS, PH_HI_U:   emit(KIND_ERROR, 8'h00, ERR_UNP_HIGH);
                  default:             emit(KIND_ERROR, 8'h00, ERR_MALFORMED);
               endcase
            end
            clear_state();
         end
         if (burst.size() > 0) begin
            r = burst[burst.size() - 1];
            r.run_end = 1'b1;
            burst[burst.size() - 1] = r;
         end
         foreach (burst[i]) pending.insert(pending.size(), burst[i]);
      endfunction

      function void check_result(logic [2:0] kind, logic [15:0] tdata, logic run_end);
         rsp_item_type want;
         if (pending.size() == 0) begin
            $display("%0t unexpected result: kind %0d byte %02h error %0d last %0b",
                     $time, kind, tdata[7:0], tdata[11:8], run_end);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (kind !== want.kind || tdata[7:0] !== want.data || tdata[11:8] !== want.err ||
             tdata[15:12] !== 4'h0 || run_end !== want.run_end) begin
            $display("%0t mismatch: expected kind %0d byte %02h error %0d last %0b,",
                     $time, want.kind, want.data, want.err, want.run_end,
                     " got kind %0d byte %02h error %0d pad %0h last %0b",
                     kind, tdata[7:0], tdata[11:8], tdata[15:12], run_end);
            mismatches++;
         end
         if (want.kind == KIND_ACCEPT) accepts++;
         if (want.kind == KIND_ERROR) codes_seen[want.err] = 1'b1;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   decode_board board;
   int          sender_idle = 0;
   int          receiver_stall = 0;
   int          texts_sent = 0;
   int          cycles = 0;

   json_string_object_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall);
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_byte(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic void add_char(ref text_type t, input logic [7:0] c);
      t.insert(t.size(), c);
   endfunction

   function automatic void add_str(ref text_type t, input string s);
      for (int i = 0; i < s.len(); i++) add_char(t, s[i]);
   endfunction

   function automatic void add_ws(ref text_type t);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) add_char(t, BLANKS[$urandom_range(0, 3)]);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 10) return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 10;
   endfunction

   function automatic void add_uesc(ref text_type t, input logic [15:0] v);
      add_str(t, "\\u");
      for (int i = 3; i >= 0; i--) add_char(t, hex_char(v[i*4 +: 4]));
   endfunction

   function automatic logic [15:0] pick_high();
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? 16'hd800 : 16'hdbff;
      return $urandom_range(16'hd800, 16'hdbff);
   endfunction

   function automatic logic [15:0] pick_low();
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? 16'hdc00 : 16'hdfff;
      return $urandom_range(16'hdc00, 16'hdfff);
   endfunction

   // one piece of string content, now and then a broken one
   function automatic void add_piece(ref text_type t);
      int          r;
      logic [7:0]  c;
      logic [15:0] v;
      string       escapes = "\"\\/bfnrt";
      r = $urandom_range(0, 99);
      if (r < 40) begin
         c = $urandom_range(8'h20, 8'h7e);
         if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
         add_char(t, c);
      end else if (r < 46) begin
         add_char(t, $urandom_range(8'h80, 8'hff));
      end else if (r < 60) begin
         add_str(t, "\\");
         add_char(t, escapes[$urandom_range(0, 7)]);
      end else if (r < 90) begin
         case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 16'h7f);
            1: v = $urandom_range(16'h80, 16'h7ff);
            2: v = $urandom_range(0, 1) ? $urandom_range(16'h800, 16'hd7ff)
                                        : $urandom_range(16'he000, 16'hffff);
            default: begin
               add_uesc(t, pick_high());
               v = pick_low();
            end
         endcase
         if (v < 16'hd800 && $urandom_range(0, 4) == 0) v = BOUND_CP[$urandom_range(0, 7)];
         add_uesc(t, v);
      end else begin
         case ($urandom_range(0, 5))
            0: add_char(t, $urandom_range(0, 8'h1f));
            1: begin
               add_str(t, "\\");
               add_char(t, $urandom_range(0, 1) ? 8'h78 : $urandom_range(8'h20, 8'hff));
            end
            2: begin
               add_str(t, "\\u");
               repeat ($urandom_range(0, 3)) add_char(t, hex_char($urandom_range(0, 15)));
               add_char(t, $urandom_range(0, 1) ? 8'h67 : 8'h20);
            end
            3: add_uesc(t, pick_low());
            4: begin
               add_uesc(t, pick_high());
               if ($urandom_range(0, 1)) add_str(t, "a");
               else add_str(t, "\\n");
            end
            default: begin
               add_uesc(t, pick_high());
               add_uesc(t, $urandom_range(0, 16'hd7ff));
            end
         endcase
      end
   endfunction

   function automatic void add_string(ref text_type t);
      add_str(t, "\"");
      repeat ($urandom_range(0, 3)) add_piece(t);
      add_str(t, "\"");
   endfunction

   function automatic text_type make_text();
      text_type t;
      int       mode;
      int       cut;
      mode = $urandom_range(0, 99);
      if (mode < 12) begin
         if ($urandom_range(0, 1)) add_str(t, "{\"");
         repeat ($urandom_range(1, 5)) add_char(t, $urandom_range(0, 255));
         return t;
      end
      add_ws(t);
      add_str(t, "{");
      for (int i = 0; i < $urandom_range(0, 2); i++) begin
         if (i > 0) begin
            add_ws(t);
            add_str(t, ",");
         end
         add_ws(t);
         add_string(t);
         add_ws(t);
         add_str(t, ":");
         add_ws(t);
         add_string(t);
      end
      add_ws(t);
      add_str(t, "}");
      add_ws(t);
      if (mode < 40) begin
         case ($urandom_range(0, 3))
            0, 1: begin
               cut = $urandom_range(1, t.size());
               while (t.size() > cut) t.delete(t.size() - 1);
            end
            2: t[$urandom_range(0, t.size() - 1)] = $urandom_range(0, 255);
            default: add_char(t, $urandom_range(8'h21, 8'h7e));
         endcase
      end
      return t;
   endfunction

   task automatic feed_byte(input logic [7:0] b, input logic last);
      if ($urandom_range(0, 99) < sender_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   task automatic feed_text(input text_type t, input int hold_after);
      for (int i = 0; i < t.size(); i++) begin
         feed_byte(t[i], i == t.size() - 1);
         if (i == hold_after) wait_results_drained();
      end
      texts_sent++;
   endtask

   task automatic run_random(input int idle, input int stall, input int budget, input bit hold);
      text_type t;
      int       sent;
      sender_idle    = idle;
      receiver_stall = stall;
      sent           = 0;
      while (sent < budget) begin
         t = make_text();
         feed_text(t, hold ? t.size() / 2 : -1);
         hold = 1'b0;
         sent += t.size();
      end
      wait_results_drained();
   endtask

   initial begin
      text_type t;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      t.delete();
      add_str(t, "{}");
      feed_text(t, -1);
      // nul escape, then the highest code point on one byte with the end of text
      t.delete();
      add_str(t, "{\"\\u0000\\uDBFF\\uDFFF");
      feed_text(t, -1);
      t.delete();
      add_str(t, "{\"");
      add_char(t, 8'h00);
      feed_text(t, -1);
      t.delete();
      add_char(t, 8'hff);
      feed_text(t, -1);
      wait_results_drained();

      run_random(0, 0, 36, 1'b0);
      run_random(77, 0, 36, 1'b1);
      run_random(0, 77, 36, 1'b0);
      run_random(24, 24, 36, 1'b0);
      repeat (12) @(posedge clock);

      $display("covered %0d texts, %0d bytes, %0d results checked across four idling mixes",
               texts_sent, board.bytes_seen, board.checked);
      $display("texts accepted %0d, error codes reported (bit per code) %011b",
               board.accepts, board.codes_seen);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
